@@ hw/rtl/jfss_pkg.sv @@
package jfss_pkg;

   // marker byte values
   localparam logic [7:0] BYTE_FILL     = 8'hFF;
   localparam logic [7:0] BYTE_SOI      = 8'hD8;
   localparam logic [7:0] BYTE_SOS      = 8'hDA;
   localparam logic [7:0] BYTE_EOI      = 8'hD9;
   localparam logic [7:0] BYTE_FRAME_LO = 8'hC0;
   localparam logic [7:0] BYTE_FRAME_HI = 8'hCF;
   localparam logic [7:0] BYTE_DHT      = 8'hC4;
   localparam logic [7:0] BYTE_JPG      = 8'hC8;
   localparam logic [7:0] BYTE_DAC      = 8'hCC;

   // smallest legal segment length (covers the length bytes themselves)
   localparam logic [15:0] MIN_SEG_LEN  = 16'd2;

   // result status codes
   localparam logic [2:0] ST_FOUND  = 3'd0;
   localparam logic [2:0] ST_NOSOI  = 3'd1;
   localparam logic [2:0] ST_STRAY  = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_BADLEN = 3'd4;
   localparam logic [2:0] ST_TRUNC  = 3'd5;

   typedef enum logic [3:0] {
      PH_SOI0  = 4'd0,
      PH_SOI1  = 4'd1,
      PH_MARK  = 4'd2,
      PH_CODE  = 4'd3,
      PH_LENH  = 4'd4,
      PH_LENL  = 4'd5,
      PH_SKIP  = 4'd6,
      PH_FLENH = 4'd7,
      PH_FLENL = 4'd8,
      PH_FPREC = 4'd9,
      PH_HTH   = 4'd10,
      PH_HTL   = 4'd11,
      PH_WDH   = 4'd12,
      PH_WDL   = 4'd13,
      PH_DONE  = 4'd14
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] frame_height;
      logic [15:0] frame_width;
   } rsp_type;

   // what one parse step hands to the output register
   typedef struct packed {
      logic    has_result;
      rsp_type rsp;
   } step_type;

endpackage

@@ hw/rtl/jfss_in_stage.sv @@
module jfss_in_stage
   import jfss_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    advance,
   output logic    item_valid,
   output req_type item
);

   logic    valid_ff, valid_in;
   req_type item_ff, item_in;
   logic    take;

   // slot frees up in the same cycle the held byte is parsed
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in = 1'b1;
         item_in  = req_data;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ hw/rtl/jfss_parser.sv @@
module jfss_parser
   import jfss_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     step,
   input  req_type  item,
   output step_type result
);

   phase_type   phase_ff, phase_in, phase_cur;
   logic [15:0] skip_ff, skip_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic [15:0] height_ff, height_in;
   logic [7:0]  width_high_ff, width_high_in;
   logic        answered_ff, answered_in, answered_cur;

   logic        give;
   logic [2:0]  give_status;
   logic [15:0] seg_len, seg_rest, skip_dec;
   logic [7:0]  b;

   function automatic logic is_frame_code(input logic [7:0] c);
      is_frame_code = (c >= BYTE_FRAME_LO) && (c <= BYTE_FRAME_HI) &&
                      (c != BYTE_DHT) && (c != BYTE_JPG) && (c != BYTE_DAC);
   endfunction

   assign b            = item.data_byte;
   // a new file restarts the parser before its first byte is used
   assign phase_cur    = item.first_byte ? PH_SOI0 : phase_ff;
   assign answered_cur = item.first_byte ? 1'b0 : answered_ff;
   assign seg_len      = {length_high_ff, b};
   assign seg_rest     = seg_len - MIN_SEG_LEN;
   assign skip_dec     = skip_ff - 16'd1;

   // result decision
   always_comb begin
      give        = 1'b0;
      give_status = ST_FOUND;
      case (phase_cur)
         PH_SOI0: begin
            if (b != BYTE_FILL) begin
               give        = 1'b1;
               give_status = ST_NOSOI;
            end
         end
         PH_SOI1: begin
            if (b != BYTE_SOI) begin
               give        = 1'b1;
               give_status = ST_NOSOI;
            end
         end
         PH_MARK: begin
            if (b != BYTE_FILL) begin
               give        = 1'b1;
               give_status = ST_STRAY;
            end
         end
         PH_CODE: begin
            if (b != BYTE_FILL && !is_frame_code(b) &&
                (b == BYTE_SOS || b == BYTE_EOI)) begin
               give        = 1'b1;
               give_status = ST_SCAN;
            end
         end
         PH_LENL: begin
            if (seg_len < MIN_SEG_LEN) begin
               give        = 1'b1;
               give_status = ST_BADLEN;
            end
         end
         PH_WDL: begin
            give        = 1'b1;
            give_status = ST_FOUND;
         end
         default: begin
         end
      endcase
      // stream ended with no answer yet
      if (!give && item.last_byte && !answered_cur) begin
         give        = 1'b1;
         give_status = ST_TRUNC;
      end
   end

   always_comb begin
      result.has_result = give;
      result.rsp.status = give_status;
      if (give_status == ST_FOUND) begin
         result.rsp.frame_height = height_ff;
         result.rsp.frame_width  = {width_high_ff, b};
      end else begin
         result.rsp.frame_height = 16'd0;
         result.rsp.frame_width  = 16'd0;
      end
   end

   // next state
   always_comb begin
      phase_in       = phase_cur;
      skip_in        = skip_ff;
      length_high_in = length_high_ff;
      height_in      = height_ff;
      width_high_in  = width_high_ff;
      answered_in    = answered_cur;
      case (phase_cur)
         PH_SOI0:  phase_in = PH_SOI1;
         PH_SOI1:  phase_in = PH_MARK;
         PH_MARK:  phase_in = PH_CODE;
         PH_CODE: begin
            if (b == BYTE_FILL) begin
               phase_in = PH_CODE;
            end else if (is_frame_code(b)) begin
               phase_in = PH_FLENH;
            end else begin
               phase_in = PH_LENH;
            end
         end
         PH_LENH: begin
            length_high_in = b;
            phase_in       = PH_LENL;
         end
         PH_LENL: begin
            skip_in  = seg_rest;
            phase_in = (seg_rest == 16'd0) ? PH_MARK : PH_SKIP;
         end
         PH_SKIP: begin
            skip_in  = skip_dec;
            phase_in = (skip_dec == 16'd0) ? PH_MARK : PH_SKIP;
         end
         PH_FLENH: phase_in = PH_FLENL;
         PH_FLENL: phase_in = PH_FPREC;
         PH_FPREC: phase_in = PH_HTH;
         PH_HTH: begin
            height_in = {b, 8'h00};
            phase_in  = PH_HTL;
         end
         PH_HTL: begin
            height_in = height_ff | {8'h00, b};
            phase_in  = PH_WDH;
         end
         PH_WDH: begin
            width_high_in = b;
            phase_in      = PH_WDL;
         end
         default:  phase_in = PH_DONE;
      endcase
      // once answered, ignore bytes until the next file
      if (give) begin
         phase_in    = PH_DONE;
         answered_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SOI0;
         answered_ff    <= 1'b0;
         skip_ff        <= 16'd0;
         length_high_ff <= 8'd0;
         height_ff      <= 16'd0;
         width_high_ff  <= 8'd0;
      end else if (step) begin
         phase_ff       <= phase_in;
         answered_ff    <= answered_in;
         skip_ff        <= skip_in;
         length_high_ff <= length_high_in;
         height_ff      <= height_in;
         width_high_ff  <= width_high_in;
      end
   end

   // a result always parks the parser until the next file
   a_give_parks: assert property (@(posedge clock) disable iff (reset)
      step && result.has_result |=> phase_ff == PH_DONE && answered_ff)
      else $error("parser not parked after result");

   // answered flag only lives in the parked phase
   a_answered_done: assert property (@(posedge clock) disable iff (reset)
      answered_ff |-> phase_ff == PH_DONE)
      else $error("answered outside done phase");

   // skipping segment body never yields a result mid-file
   a_skip_quiet: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_SKIP && !item.first_byte && !item.last_byte
      |-> !result.has_result)
      else $error("result while skipping segment");

endmodule

@@ hw/rtl/jfss_out_stage.sv @@
module jfss_out_stage
   import jfss_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    out_free,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   // register can take a new result when empty or draining this cycle
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

@@ hw/rtl/jpeg_frame_size_scanner.sv @@
// A byte transferred into the input register is parsed combinationally; any result it gives
// is loaded into the output register once that register is free, and rsp_valid is then high.
// Throughput: one byte per cycle; the parse step is a single state update per byte,
// and input taking pauses only while a finished result waits in the output register.
// Reset (synchronous, active high) empties both registers and returns the parser
// to expecting the first start-marker byte.
module jpeg_frame_size_scanner
   import jfss_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic     item_valid;
   req_type  item;
   step_type result;
   logic     out_free;
   logic     advance;

   // parse the held byte unless its result has nowhere to go
   assign advance = item_valid && (!result.has_result || out_free);

   jfss_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   jfss_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item),
      .result (result)
   );

   jfss_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && result.has_result),
      .load_data (result.rsp),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
